>>> hdl/tnrx_pkg.sv
// ----------------------------------------------------------------------------
// tnrx_pkg
// Shared types, telnet codes and reply helpers for the telnet receive filter.
// ----------------------------------------------------------------------------
package tnrx_pkg;

  localparam logic [7:0] TN_IAC          = 8'd255;
  localparam logic [7:0] TN_DONT         = 8'd254;
  localparam logic [7:0] TN_DO           = 8'd253;
  localparam logic [7:0] TN_WONT         = 8'd252;
  localparam logic [7:0] TN_WILL         = 8'd251;
  localparam logic [7:0] TN_SB           = 8'd250;
  localparam logic [7:0] TN_SE           = 8'd240;
  localparam logic [7:0] TN_CMD_MIN      = 8'd250;
  localparam logic [7:0] TN_OPT_ECHO     = 8'd1;
  localparam logic [7:0] TN_OPT_LINEMODE = 8'd34;
  localparam logic [7:0] TN_NEWLINE      = 8'd10;
  localparam logic [7:0] TN_LM_EDIT      = 8'd1;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_TELNET_ENABLE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EOL_TRANSLATE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_EOL_FIRST     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_EOL_SKIP      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ECHO_WILL     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_LINEMODE_WILL = 3'd5;

  localparam logic DEST_APP  = 1'b0;
  localparam logic DEST_LINE = 1'b1;

  // What the back end has to emit for one classified input byte.
  typedef enum logic [1:0] {
    JOB_DATA,
    JOB_DONT,
    JOB_WONT,
    JOB_LINEMODE
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] data;
  } job_t;

  // Index of the final beat of a job.
  function automatic logic [2:0] job_last_idx(input job_kind_t kind);
    case (kind)
      JOB_DATA:     job_last_idx = 3'd0;
      JOB_DONT:     job_last_idx = 3'd2;
      JOB_WONT:     job_last_idx = 3'd2;
      JOB_LINEMODE: job_last_idx = 3'd6;
      default:      job_last_idx = 3'd0;
    endcase
  endfunction

  // IAC SB LINEMODE MODE EDIT IAC SE
  function automatic logic [7:0] linemode_byte(input logic [2:0] idx);
    case (idx)
      3'd0:    linemode_byte = TN_IAC;
      3'd1:    linemode_byte = TN_SB;
      3'd2:    linemode_byte = TN_OPT_LINEMODE;
      3'd3:    linemode_byte = TN_LM_EDIT;
      3'd4:    linemode_byte = TN_LM_EDIT;
      3'd5:    linemode_byte = TN_IAC;
      default: linemode_byte = TN_SE;
    endcase
  endfunction

endpackage

>>> hdl/tnrx_front.sv
// ----------------------------------------------------------------------------
// tnrx_front
// Parses received bytes, holds the configuration and issues emit jobs.
// ----------------------------------------------------------------------------
module tnrx_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    rx_byte,
  input  logic                          cfg_valid,
  input  logic [tnrx_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          job_full,
  output logic                          job_push,
  output tnrx_pkg::job_t                job
);

  typedef enum logic [2:0] {
    PH_NORMAL   = 3'd0,
    PH_IAC      = 3'd1,
    PH_OPT      = 3'd2,
    PH_SB_FIRST = 3'd3,
    PH_SB_SCAN  = 3'd4,
    PH_EOL_SKIP = 3'd5
  } phase_t;

  logic       telnet_enable;
  logic       eol_translate;
  logic [7:0] eol_first;
  logic [1:0] eol_skip;
  logic       echo_will;
  logic       linemode_will;

  phase_t     phase, phase_next;
  logic [7:0] held_command, held_command_next;
  logic [7:0] prev_sub_byte, prev_sub_byte_next;
  logic [1:0] skip_left, skip_left_next;

  logic       accept;
  logic       emit;
  tnrx_pkg::job_t job_new;

  assign in_ready = !job_full;
  assign accept   = in_valid && in_ready;
  assign job_push = accept && emit;
  assign job      = job_new;

  always_comb begin
    phase_next         = phase;
    held_command_next  = held_command;
    prev_sub_byte_next = prev_sub_byte;
    skip_left_next     = skip_left;
    emit               = 1'b0;
    job_new.kind       = tnrx_pkg::JOB_DATA;
    job_new.data       = rx_byte;
    case (phase)
      PH_IAC: begin
        if (rx_byte == tnrx_pkg::TN_IAC) begin
          phase_next = PH_NORMAL;
          emit       = 1'b1;
        end else if (rx_byte >= tnrx_pkg::TN_CMD_MIN) begin
          held_command_next = rx_byte;
          phase_next        = PH_OPT;
        end else begin
          phase_next = PH_NORMAL;
        end
      end
      PH_OPT: begin
        phase_next = PH_NORMAL;
        if (held_command == tnrx_pkg::TN_SB) begin
          phase_next = PH_SB_FIRST;
        end else if (held_command == tnrx_pkg::TN_WILL) begin
          emit = 1'b1;
          if (rx_byte == tnrx_pkg::TN_OPT_LINEMODE && linemode_will) begin
            job_new.kind = tnrx_pkg::JOB_LINEMODE;
          end else begin
            job_new.kind = tnrx_pkg::JOB_DONT;
          end
        end else if (held_command == tnrx_pkg::TN_DO) begin
          if (!(rx_byte == tnrx_pkg::TN_OPT_ECHO && echo_will)) begin
            emit         = 1'b1;
            job_new.kind = tnrx_pkg::JOB_WONT;
          end
        end
      end
      PH_SB_FIRST: begin
        prev_sub_byte_next = rx_byte;
        phase_next         = PH_SB_SCAN;
      end
      PH_SB_SCAN: begin
        if (prev_sub_byte == tnrx_pkg::TN_IAC && rx_byte == tnrx_pkg::TN_SE) begin
          phase_next = PH_NORMAL;
        end
        prev_sub_byte_next = rx_byte;
      end
      PH_EOL_SKIP: begin
        skip_left_next = skip_left - 2'd1;
        if (skip_left == 2'd1) begin
          phase_next = PH_NORMAL;
        end
      end
      default: begin
        // Normal data phase; the unused phase codes land here as well.
        phase_next = PH_NORMAL;
        if (telnet_enable && rx_byte == tnrx_pkg::TN_IAC) begin
          phase_next = PH_IAC;
        end else if (eol_translate && rx_byte == eol_first) begin
          skip_left_next = eol_skip;
          if (eol_skip != 2'd0) begin
            phase_next = PH_EOL_SKIP;
          end
          emit         = 1'b1;
          job_new.data = tnrx_pkg::TN_NEWLINE;
        end else begin
          emit = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_NORMAL;
      held_command  <= '0;
      prev_sub_byte <= '0;
      skip_left     <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      held_command  <= held_command_next;
      prev_sub_byte <= prev_sub_byte_next;
      skip_left     <= skip_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      telnet_enable <= 1'b0;
      eol_translate <= 1'b1;
      eol_first     <= 8'd13;
      eol_skip      <= 2'd0;
      echo_will     <= 1'b0;
      linemode_will <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tnrx_pkg::CFG_TELNET_ENABLE: telnet_enable <= cfg_data[0];
        tnrx_pkg::CFG_EOL_TRANSLATE: eol_translate <= cfg_data[0];
        tnrx_pkg::CFG_EOL_FIRST:     eol_first     <= cfg_data;
        tnrx_pkg::CFG_EOL_SKIP:      eol_skip      <= cfg_data[1:0];
        tnrx_pkg::CFG_ECHO_WILL:     echo_will     <= cfg_data[0];
        tnrx_pkg::CFG_LINEMODE_WILL: linemode_will <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/tnrx_queue.sv
// ----------------------------------------------------------------------------
// tnrx_queue
// Small job queue between the parser and the beat emitter.
// ----------------------------------------------------------------------------
module tnrx_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tnrx_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output tnrx_pkg::job_t head_job
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

  tnrx_pkg::job_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_MAX);
  assign not_empty = (count != '0);
  assign head_job  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_MAX) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_MAX) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/tnrx_back.sv
// ----------------------------------------------------------------------------
// tnrx_back
// Expands queued jobs into output beats behind a registered output stage.
// ----------------------------------------------------------------------------
module tnrx_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_avail,
  input  tnrx_pkg::job_t head_job,
  output logic           job_pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,
  output logic           m_tuser,
  output logic           m_tlast
);

  logic           cur_valid;
  tnrx_pkg::job_t cur_job;
  logic [2:0]     idx;

  logic           out_load;
  logic           last_beat;
  logic [7:0]     beat_byte;
  logic           beat_dest;

  assign out_load  = !m_tvalid || m_tready;
  assign last_beat = (idx == tnrx_pkg::job_last_idx(cur_job.kind));
  assign job_pop   = job_avail && (!cur_valid || (out_load && last_beat));

  always_comb begin
    beat_dest = tnrx_pkg::DEST_LINE;
    beat_byte = cur_job.data;
    case (cur_job.kind)
      tnrx_pkg::JOB_DATA: begin
        beat_dest = tnrx_pkg::DEST_APP;
      end
      tnrx_pkg::JOB_DONT, tnrx_pkg::JOB_WONT: begin
        case (idx)
          3'd0:    beat_byte = tnrx_pkg::TN_IAC;
          3'd1:    beat_byte = (cur_job.kind == tnrx_pkg::JOB_DONT) ?
                               tnrx_pkg::TN_DONT : tnrx_pkg::TN_WONT;
          default: beat_byte = cur_job.data;
        endcase
      end
      tnrx_pkg::JOB_LINEMODE: begin
        beat_byte = tnrx_pkg::linemode_byte(idx);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= cur_valid;
      end
      if (job_pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (cur_valid && out_load) begin
        if (last_beat) begin
          cur_valid <= 1'b0;
          idx       <= '0;
        end else begin
          idx <= idx + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur_job <= head_job;
    end
    if (out_load && cur_valid) begin
      m_tdata <= beat_byte;
      m_tuser <= beat_dest;
      m_tlast <= last_beat;
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> idx <= tnrx_pkg::job_last_idx(cur_job.kind))
    else $error("beat index past the end of its job");

  a_last_beat_flagged: assert property (@(posedge clk) disable iff (rst)
    out_load && cur_valid && last_beat |=> m_tvalid && m_tlast)
    else $error("final beat of a job not marked last");

  a_data_is_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == tnrx_pkg::DEST_APP) |-> m_tlast)
    else $error("application data beat without last");

  a_no_pop_mid_job: assert property (@(posedge clk) disable iff (rst)
    job_pop && cur_valid |-> out_load && last_beat)
    else $error("job taken from queue while current job unfinished");
`endif

endmodule

>>> hdl/telnet_rx_option_filter_unit.sv
// ----------------------------------------------------------------------------
// telnet_rx_option_filter_unit
// Telnet receive filter: strips IAC commands, answers option requests and
// translates the end-of-line sequence.
// ----------------------------------------------------------------------------
// One received byte is taken per clock while the job queue has room. A byte
// yields no beat, one application data beat (tuser 0), or a reply to the line
// (tuser 1) of 3 beats (IAC DONT/WONT opt) or 7 beats (linemode edit
// subnegotiation); tlast marks the final beat caused by a byte. The output
// emitter sends one beat per clock while m_tready is high, so plain data
// flows at one byte per cycle without back-pressure. A byte's first beat is
// valid after the queue write, job load and output register. Input stalls
// only when the queue holds QUEUE_DEPTH jobs. Configuration writes are
// accepted every cycle and should be made while no byte is in flight.
module telnet_rx_option_filter_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tuser,   // [0] dest
  output logic       m_tlast,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [tnrx_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic           job_push;
  logic           job_full;
  logic           job_pop;
  logic           job_avail;
  tnrx_pkg::job_t push_job;
  tnrx_pkg::job_t head_job;

  assign cfg_ready = 1'b1;

  tnrx_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .rx_byte   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job_full  (job_full),
    .job_push  (job_push),
    .job       (push_job)
  );

  tnrx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_job  (push_job),
    .full      (job_full),
    .pop       (job_pop),
    .not_empty (job_avail),
    .head_job  (head_job)
  );

  tnrx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_avail (job_avail),
    .head_job  (head_job),
    .job_pop   (job_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
